// ===== rtl/world_to_screen_projection_defines.svh =====
// Assertion macros for the projection block.
// Used by the top level only; no other dependencies.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
// implication checked on every clock, skipped in reset
`define WSP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define WSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/wsp_pkg.sv =====
// Shared constants for the projection block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wsp_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COEF_W          = 32;
    localparam int IDX_W           = 5;
    localparam int DIM_W           = 14;
    localparam int OUT_W           = 32;
    localparam int NUM_VIEW        = 12;
    localparam int NUM_PROJ        = 16;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd1080;
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PROJECT = 1'b1;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/wsp_dot3.sv =====
// One three-term dot product plus translation, three register stages:
// multiply, round and clamp, sum and saturate. Uses wsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wsp_dot3 #(
    parameter int AW = 32,
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [AW-1:0] a0, a1, a2,
    input  wire logic signed [wsp_pkg::COEF_W-1:0] c0, c1, c2, t,
    output logic signed [CW-1:0]      y
);
    import wsp_pkg::*;
    localparam int PW = AW + COEF_W;
    localparam int RW = 62;
    localparam logic [RW-1:0] CAP = RW'(1) << 60;

    logic signed [PW-1:0] p_reg [3];
    logic signed [COEF_W-1:0] t1_reg, t2_reg;
    logic signed [RW-1:0] r_reg [3];
    logic signed [CW-1:0] y_reg;

    function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] p);
        logic neg;
        logic [PW:0] m, s;
        logic [PW:0] q;
        logic [RW-1:0] r;
        begin
            neg = p[PW-1];
            m = neg ? (PW+1)'(-$signed({p[PW-1], p})) : (PW+1)'({1'b0, p});
            s = m + ((PW+1)'(1) << (FB-1));
            q = s >> FB;
            if (q > (PW+1)'(CAP)) r = CAP; else r = RW'(q);
            rnd = neg ? -$signed(r) : $signed(r);
        end
    endfunction

    localparam int SW = RW + 3;
    localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (CW-1)) - 1);
    localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);
    logic signed [SW-1:0] sum;

    always_comb begin
        sum = SW'(r_reg[0]) + SW'(r_reg[1]) + SW'(r_reg[2]) + SW'(t2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= PW'(a0) * PW'(c0);
            p_reg[1] <= PW'(a1) * PW'(c1);
            p_reg[2] <= PW'(a2) * PW'(c2);
            t1_reg   <= t;
            for (int i = 0; i < 3; i++) r_reg[i] <= rnd(p_reg[i]);
            t2_reg   <= t1_reg;
            if (sum > CMAX)      y_reg <= CW'(CMAX);
            else if (sum < CMIN) y_reg <= CW'(CMIN);
            else                 y_reg <= CW'(sum);
        end
    end
    assign y = y_reg;
endmodule
`default_nettype wire

// ===== rtl/wsp_divider.sv =====
// Pipelined restoring divider: (num * 2^FB) / den, den > 0, truncated,
// one quotient bit per stage, saturated to CW bits. Uses wsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wsp_divider #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [CW-1:0] num,
    input  wire logic signed [CW-1:0] den,
    output logic signed [CW-1:0]      q
);
    import wsp_pkg::*;
    localparam int NW = CW + FB;     // dividend bits, magnitude
    localparam int QW = NW;
    logic [NW-1:0] n_reg [NW+1];
    logic [CW-1:0] d_reg [NW+1];
    logic [CW:0]   r_reg [NW+1];
    logic [QW-1:0] q_reg [NW+1];
    logic          s_reg [NW+1];
    logic signed [CW-1:0] o_reg;

    localparam logic [QW-1:0] QMAX = QW'((64'd1 << (CW-1)) - 1);
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0] <= {(num[CW-1] ? CW'(-num) : CW'(num)), FB'(0)};
            d_reg[0] <= CW'(den);
            r_reg[0] <= '0;
            q_reg[0] <= '0;
            s_reg[0] <= num[CW-1];
            for (int i = 0; i < NW; i++) begin
                logic [CW:0] tr;
                tr = {r_reg[i][CW-1:0], n_reg[i][NW-1]};
                if (tr >= {1'b0, d_reg[i]}) begin
                    r_reg[i+1] <= tr - {1'b0, d_reg[i]};
                    q_reg[i+1] <= {q_reg[i][QW-2:0], 1'b1};
                end else begin
                    r_reg[i+1] <= tr;
                    q_reg[i+1] <= {q_reg[i][QW-2:0], 1'b0};
                end
                n_reg[i+1] <= n_reg[i] << 1;
                d_reg[i+1] <= d_reg[i];
                s_reg[i+1] <= s_reg[i];
            end
            if (s_reg[NW])
                o_reg <= (q_reg[NW] > QMAX) ? CW'(QMAX + QW'(1)) : CW'(-q_reg[NW]);
            else
                o_reg <= (q_reg[NW] > QMAX) ? CW'(QMAX) : CW'(q_reg[NW]);
        end
    end
    assign q = o_reg;
endmodule
`default_nettype wire

// ===== rtl/world_to_screen_projection.sv =====
// Top level of the world-to-screen projection pipeline.
// Depends on wsp_pkg, wsp_dot3, wsp_divider and the defines header.
//
// Usage: words enter on s_ (valid/ready). kind=0 loads one matrix
// coefficient (index 0-11 view, 12-27 projection, others ignored) and
// yields no result word. kind=1 projects a point; one result word leaves
// on m_ (valid/ready) with screen_x/y in Q.FRAC_BITS, visible and in_front.
// Depth: 3 view stages + 3 projection stages + CW+FB+2 divider stages
// + 2 viewport stages. Throughput: one word a cycle while the output is
// not stalled; the divider's bit-per-stage pipeline sets the depth.
// A coefficient load takes effect for every later point word.
// The whole pipeline advances only while its output slot is empty or being
// taken, so a stalled receiver freezes every stage and nothing is lost.
// Reset (aresetn low, synchronous) clears all coefficients to zero, the
// screen size to 1920x1080, and every stage valid bit.
// Configuration: cfg_ index 0 width, 1 height; always ready.
`timescale 1ns / 1ps
`default_nettype none
`include "world_to_screen_projection_defines.svh"
module world_to_screen_projection #(
    parameter int COORD_WIDTH = wsp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = wsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic s_kind,
    input  wire logic [wsp_pkg::IDX_W-1:0] s_coef_index,
    input  wire logic signed [wsp_pkg::COEF_W-1:0] s_coef_value,
    input  wire logic signed [wsp_pkg::COEF_W-1:0] s_point_x,
    input  wire logic signed [wsp_pkg::COEF_W-1:0] s_point_y,
    input  wire logic signed [wsp_pkg::COEF_W-1:0] s_point_z,
    output logic      m_valid,
    input  wire logic m_ready,
    output logic signed [wsp_pkg::OUT_W-1:0] m_screen_x,
    output logic signed [wsp_pkg::OUT_W-1:0] m_screen_y,
    output logic      m_visible,
    output logic      m_in_front,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic cfg_index,
    input  wire logic [wsp_pkg::DIM_W-1:0] cfg_data
);
    import wsp_pkg::*;
    localparam int CW = COORD_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int DEPTH = 3 + 3 + (CW + FB + 2) + 2;

    logic signed [COEF_W-1:0] view_reg [NUM_VIEW];
    logic signed [COEF_W-1:0] proj_reg [NUM_PROJ];
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DEPTH-1:0] vld_reg;
    logic adv, take;
    // projection loads trail by the three view stages, in step with the points
    logic [2:0] pld_vld_reg;
    logic [3:0] pld_idx_reg [3];
    logic signed [COEF_W-1:0] pld_val_reg [3];

    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign take      = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_VIEW; i++) view_reg[i] <= '0;
            for (int i = 0; i < NUM_PROJ; i++) proj_reg[i] <= '0;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            vld_reg    <= '0;
            pld_vld_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                pld_idx_reg[i] <= '0;
                pld_val_reg[i] <= '0;
            end
        end else begin
            if (take && s_kind == KIND_LOAD) begin
                if (s_coef_index < IDX_W'(NUM_VIEW))
                    view_reg[s_coef_index[3:0]] <= s_coef_value;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_WIDTH) width_reg <= cfg_data;
                else                        height_reg <= cfg_data;
            end
            if (adv) begin
                vld_reg <= {vld_reg[DEPTH-2:0], take && s_kind == KIND_PROJECT};
                pld_vld_reg <= {pld_vld_reg[1:0], take && s_kind == KIND_LOAD
                    && s_coef_index >= IDX_W'(NUM_VIEW)
                    && s_coef_index < IDX_W'(NUM_VIEW + NUM_PROJ)};
                pld_idx_reg[0] <= 4'(s_coef_index - IDX_W'(NUM_VIEW));
                pld_val_reg[0] <= s_coef_value;
                for (int i = 1; i < 3; i++) begin
                    pld_idx_reg[i] <= pld_idx_reg[i-1];
                    pld_val_reg[i] <= pld_val_reg[i-1];
                end
                if (pld_vld_reg[2]) proj_reg[pld_idx_reg[2]] <= pld_val_reg[2];
            end
        end
    end

    // camera coordinates, columns of the view matrix
    logic signed [CW-1:0] cx, cy, cz, kx, ky, kw;
    wsp_dot3 #(.AW(COEF_W), .CW(CW), .FB(FB)) u_vx (aclk, adv, s_point_x, s_point_y,
        s_point_z, view_reg[0], view_reg[3], view_reg[6], view_reg[9], cx);
    wsp_dot3 #(.AW(COEF_W), .CW(CW), .FB(FB)) u_vy (aclk, adv, s_point_x, s_point_y,
        s_point_z, view_reg[1], view_reg[4], view_reg[7], view_reg[10], cy);
    wsp_dot3 #(.AW(COEF_W), .CW(CW), .FB(FB)) u_vz (aclk, adv, s_point_x, s_point_y,
        s_point_z, view_reg[2], view_reg[5], view_reg[8], view_reg[11], cz);
    // clip coordinates (projection loads land three stages late, so each
    // point meets the matrix it was sent under)
    wsp_dot3 #(.AW(CW), .CW(CW), .FB(FB)) u_kx (aclk, adv, cx, cy, cz,
        proj_reg[0], proj_reg[4], proj_reg[8], proj_reg[12], kx);
    wsp_dot3 #(.AW(CW), .CW(CW), .FB(FB)) u_ky (aclk, adv, cx, cy, cz,
        proj_reg[1], proj_reg[5], proj_reg[9], proj_reg[13], ky);
    wsp_dot3 #(.AW(CW), .CW(CW), .FB(FB)) u_kw (aclk, adv, cx, cy, cz,
        proj_reg[3], proj_reg[7], proj_reg[11], proj_reg[15], kw);

    // in-front flag travels alongside the divider
    localparam int DD = CW + FB + 2;
    logic [DD-1:0] front_reg;
    logic signed [CW-1:0] den;
    logic signed [CW-1:0] nx, ny;
    assign den = (kw > 0) ? kw : CW'(1);
    always_ff @(posedge aclk) begin
        if (adv) front_reg <= {front_reg[DD-2:0], kw > 0};
    end
    wsp_divider #(.CW(CW), .FB(FB)) u_dx (aclk, adv, kx, den, nx);
    wsp_divider #(.CW(CW), .FB(FB)) u_dy (aclk, adv, ky, den, ny);

    // viewport map: products, then halving, bounds and saturation
    localparam int VW = CW + DIM_W + 3;
    logic signed [VW-1:0] ax_reg, ay_reg, wone_reg, hone_reg;
    logic f1_reg;
    logic signed [OUT_W-1:0] sx_reg, sy_reg;
    logic vis_reg, f2_reg;
    logic signed [VW-1:0] one_s, sxv, syv;
    localparam logic signed [VW-1:0] OMAX = VW'(64'sd2147483647);
    localparam logic signed [VW-1:0] OMIN = -OMAX - VW'(1);
    assign one_s = VW'(1) <<< FB;
    assign sxv = (wone_reg + ax_reg + one_s) >>> 1;
    assign syv = (hone_reg - ay_reg - one_s) >>> 1;
    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg   <= VW'(nx) * $signed({1'b0, width_reg});
            ay_reg   <= VW'(ny) * $signed({1'b0, height_reg});
            wone_reg <= VW'({1'b0, width_reg}) <<< FB;
            hone_reg <= VW'({1'b0, height_reg}) <<< FB;
            f1_reg   <= front_reg[DD-1];
            f2_reg   <= f1_reg;
            vis_reg  <= f1_reg && !(sxv > wone_reg || sxv < 0 || syv > hone_reg || syv < 0);
            if (!f1_reg) begin
                sx_reg <= '0;
                sy_reg <= '0;
            end else begin
                sx_reg <= sxv > OMAX ? OUT_W'(OMAX) : (sxv < OMIN ? OUT_W'(OMIN) : OUT_W'(sxv));
                sy_reg <= syv > OMAX ? OUT_W'(OMAX) : (syv < OMIN ? OUT_W'(OMIN) : OUT_W'(syv));
            end
        end
    end

    assign m_valid    = vld_reg[DEPTH-1];
    assign m_screen_x = sx_reg;
    assign m_screen_y = sy_reg;
    assign m_visible  = vis_reg;
    assign m_in_front = f2_reg;

    `WSP_ASSERT_IMPL(a_vis_front, aclk, aresetn, m_valid && m_visible, m_in_front, "visible behind camera")
    `WSP_ASSERT_IMPL(a_behind_zero, aclk, aresetn, m_valid && !m_in_front, m_screen_x == 0 && m_screen_y == 0, "behind camera not zero")
    `WSP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_screen_x), "stalled word changed")
endmodule
`default_nettype wire
